// ===== rtl/core/ptt_pkg.sv =====
package ptt_pkg;

    // Fixed field widths of the item and result ports
    localparam int TIME_W   = 64;
    localparam int PERIOD_W = 32;
    localparam int COUNT_W  = 32;
    localparam int TAG_IN_W = 16;
    localparam int SLOT_W   = 4;
    localparam int KIND_W   = 2;

    // Operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

    // Add status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADD  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // Outcome of evaluating one slot against the current time
    typedef struct packed {
        logic fire;
        logic retire;
    } eval_t;

endpackage

// ===== rtl/core/ptt_mem.sv =====
module ptt_mem #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ptt_eval.sv =====
module ptt_eval (
    input  logic [ptt_pkg::TIME_W-1:0]   last_time,
    input  logic [ptt_pkg::PERIOD_W-1:0] period,
    input  logic [ptt_pkg::COUNT_W-1:0]  count,
    input  logic [ptt_pkg::COUNT_W-1:0]  limit,
    input  logic [ptt_pkg::TIME_W-1:0]   now,
    output ptt_pkg::eval_t               res,
    output logic [ptt_pkg::COUNT_W-1:0]  count_inc
);

    logic [ptt_pkg::TIME_W:0] due;

    // Due time with carry; a carry out means the slot never fires
    assign due = {1'b0, last_time}
               + {{(ptt_pkg::TIME_W - ptt_pkg::PERIOD_W + 1){1'b0}}, period};

    assign count_inc  = count + ptt_pkg::COUNT_W'(1);
    assign res.fire   = !due[ptt_pkg::TIME_W] && (due[ptt_pkg::TIME_W-1:0] < now);
    assign res.retire = (limit != '0) && (limit < count_inc);

endmodule

// ===== rtl/core/periodic_timer_task_table_core.sv =====
// Periodic timer task table. An add transfer claims the lowest free slot and
// answers with the slot or table full via S_ADD and the output register.
// A tick transfer walks all SLOTS slots, reading used ones from the slot
// memory, one read a cycle while no fired result waits on a busy output;
// it evaluates a used slot the cycle after its read, writes it back when it
// fires, and ends with a done result. The slot memory has a single read
// port. Slot occupancy sits in flip-flops cleared by reset; the memory
// itself needs no clearing since a slot is always fully written by an add
// before it is read. One item is worked at a time; in_ready is high between
// items while the output register may still hold a result.
module periodic_timer_task_table_core #(
    parameter int SLOTS    = 16,
    parameter int TAG_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] period,
    input  logic [31:0] max_fires,
    input  logic [15:0] task_tag,
    input  logic [63:0] now,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic        status,
    output logic [3:0]  slot,
    output logic [15:0] fired_tag,
    output logic        retired,
    output logic        last
);

    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TAG_LSB  = 0;
    localparam int LIM_LSB  = TAG_BITS;
    localparam int CNT_LSB  = LIM_LSB + ptt_pkg::COUNT_W;
    localparam int PER_LSB  = CNT_LSB + ptt_pkg::COUNT_W;
    localparam int LAST_LSB = PER_LSB + ptt_pkg::PERIOD_W;
    localparam int ENT_W    = LAST_LSB + ptt_pkg::TIME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    ptt_pkg::state_t state_reg, state_next;

    logic [SLOTS-1:0]                 used_reg, used_next;
    logic [ptt_pkg::TIME_W-1:0]       now_reg, now_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic                             scan_active_reg, scan_active_next;
    logic                             eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0]                 eval_idx_reg, eval_idx_next;
    logic                             add_full_reg, add_full_next;
    logic [IDX_W-1:0]                 add_slot_reg, add_slot_next;

    logic                             out_valid_reg, out_valid_next;
    logic [ptt_pkg::KIND_W-1:0]       kind_reg, kind_next;
    logic                             status_reg, status_next;
    logic [ptt_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic [ptt_pkg::TAG_IN_W-1:0]     tag_reg, tag_next;
    logic                             retired_reg, retired_next;
    logic                             last_reg, last_next;

    logic                             in_xfer;
    logic                             out_busy;
    logic                             out_load;
    logic                             stall;
    logic                             free_found;
    logic [IDX_W-1:0]                 free_idx;
    logic [IDX_W-1:0]                 slot_src;
    logic [IDX_W+ptt_pkg::SLOT_W-1:0] slot_wide;
    logic [TAG_BITS+ptt_pkg::TAG_IN_W-1:0] tag_in_wide;
    logic [TAG_BITS+ptt_pkg::TAG_IN_W-1:0] tag_out_wide;
    logic [TAG_BITS-1:0]              tag_store;

    logic                             mem_we;
    logic [IDX_W-1:0]                 mem_waddr;
    logic [ENT_W-1:0]                 mem_wdata;
    logic                             mem_re;
    logic [ENT_W-1:0]                 mem_rdata;

    ptt_pkg::eval_t                   ev;
    logic [ptt_pkg::COUNT_W-1:0]      count_inc;

    // Slot memory: last fire time, period, count, limit, tag
    ptt_mem #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    // Fire decision for the slot whose read data the slot memory holds
    ptt_eval u_eval (
        .last_time (mem_rdata[LAST_LSB +: ptt_pkg::TIME_W]),
        .period    (mem_rdata[PER_LSB +: ptt_pkg::PERIOD_W]),
        .count     (mem_rdata[CNT_LSB +: ptt_pkg::COUNT_W]),
        .limit     (mem_rdata[LIM_LSB +: ptt_pkg::COUNT_W]),
        .now       (now_reg),
        .res       (ev),
        .count_inc (count_inc)
    );

    // Handshake and stall terms
    assign in_ready = (state_reg == ptt_pkg::S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_busy = out_valid_reg && !out_ready;
    assign stall    = eval_valid_reg && ev.fire && out_busy;
    assign mem_re   = (state_reg == ptt_pkg::S_SCAN) && scan_active_reg && !stall
                      && used_reg[idx_reg];

    // Tag width conversion in and out of storage
    assign tag_in_wide  = {{TAG_BITS{1'b0}}, task_tag};
    assign tag_store    = tag_in_wide[TAG_BITS-1:0];
    assign tag_out_wide = {{ptt_pkg::TAG_IN_W{1'b0}}, mem_rdata[TAG_LSB +: TAG_BITS]};
    assign slot_wide    = {{ptt_pkg::SLOT_W{1'b0}}, slot_src};

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Sequencer, scan pipeline and output register loading
    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        now_next         = now_reg;
        idx_next         = idx_reg;
        scan_active_next = scan_active_reg;
        eval_valid_next  = eval_valid_reg;
        eval_idx_next    = eval_idx_reg;
        add_full_next    = add_full_reg;
        add_slot_next    = add_slot_reg;
        mem_we           = 1'b0;
        mem_waddr        = eval_idx_reg;
        mem_wdata        = {now_reg,
                            mem_rdata[PER_LSB +: ptt_pkg::PERIOD_W],
                            count_inc,
                            mem_rdata[LIM_LSB +: ptt_pkg::COUNT_W],
                            mem_rdata[TAG_LSB +: TAG_BITS]};
        out_load         = 1'b0;
        slot_src         = eval_idx_reg;
        kind_next        = kind_reg;
        status_next      = ptt_pkg::ST_OK;
        tag_next         = '0;
        retired_next     = 1'b0;
        last_next        = 1'b0;

        unique case (state_reg)
            ptt_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (operation == ptt_pkg::OP_ADD)
                    begin
                        add_full_next = !free_found;
                        add_slot_next = free_found ? free_idx : '0;
                        if (free_found)
                        begin
                            mem_we              = 1'b1;
                            mem_waddr           = free_idx;
                            mem_wdata           = {{ptt_pkg::TIME_W{1'b0}}, period,
                                                   {ptt_pkg::COUNT_W{1'b0}}, max_fires,
                                                   tag_store};
                            used_next[free_idx] = 1'b1;
                        end
                        state_next = ptt_pkg::S_ADD;
                    end
                    else
                    begin
                        now_next         = now;
                        idx_next         = '0;
                        scan_active_next = 1'b1;
                        eval_valid_next  = 1'b0;
                        state_next       = ptt_pkg::S_SCAN;
                    end
                end
            end
            ptt_pkg::S_ADD:
            begin
                slot_src = add_slot_reg;
                if (!out_busy)
                begin
                    out_load    = 1'b1;
                    kind_next   = ptt_pkg::KIND_ADD;
                    status_next = add_full_reg ? ptt_pkg::ST_FULL : ptt_pkg::ST_OK;
                    last_next   = 1'b1;
                    state_next  = ptt_pkg::S_IDLE;
                end
            end
            ptt_pkg::S_SCAN:
            begin
                if (!stall)
                begin
                    // Evaluate stage: write back and report a firing
                    if (eval_valid_reg && ev.fire)
                    begin
                        mem_we       = 1'b1;
                        out_load     = 1'b1;
                        kind_next    = ptt_pkg::KIND_FIRE;
                        tag_next     = tag_out_wide[ptt_pkg::TAG_IN_W-1:0];
                        retired_next = ev.retire;
                        if (ev.retire)
                        begin
                            used_next[eval_idx_reg] = 1'b0;
                        end
                    end
                    // Read stage: issue the next slot
                    if (scan_active_reg)
                    begin
                        eval_valid_next = used_reg[idx_reg];
                        eval_idx_next   = idx_reg;
                        if (idx_reg == LAST_IDX)
                        begin
                            scan_active_next = 1'b0;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        eval_valid_next = 1'b0;
                    end
                end
                if (!scan_active_reg && !eval_valid_reg)
                begin
                    state_next = ptt_pkg::S_DONE;
                end
            end
            ptt_pkg::S_DONE:
            begin
                if (!out_busy)
                begin
                    out_load   = 1'b1;
                    kind_next  = ptt_pkg::KIND_DONE;
                    slot_src   = '0;
                    last_next  = 1'b1;
                    state_next = ptt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ptt_pkg::S_IDLE;
            end
        endcase

        slot_next = slot_wide[ptt_pkg::SLOT_W-1:0];
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ptt_pkg::S_IDLE;
            used_reg        <= '0;
            idx_reg         <= '0;
            scan_active_reg <= 1'b0;
            eval_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            idx_reg         <= idx_next;
            scan_active_reg <= scan_active_next;
            eval_valid_reg  <= eval_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        eval_idx_reg <= eval_idx_next;
        add_full_reg <= add_full_next;
        add_slot_reg <= add_slot_next;
        if (out_load)
        begin
            kind_reg    <= kind_next;
            status_reg  <= status_next;
            slot_reg    <= slot_next;
            tag_reg     <= tag_next;
            retired_reg <= retired_next;
            last_reg    <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign fired_tag = tag_reg;
    assign retired   = retired_reg;
    assign last      = last_reg;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_SLOTS = 16;

    // One input transfer
    typedef struct {
        logic        op;
        logic [31:0] period;
        logic [31:0] limit;
        logic [15:0] tag;
        logic [63:0] now;
    } timer_item_t;

    // One output transfer
    typedef struct {
        logic [1:0]  kind;
        logic        status;
        logic [3:0]  slot;
        logic [15:0] tag;
        logic        retired;
        logic        last;
    } timer_result_t;

    // Tracks the task table and checks every result against what it predicts
    class task_table_tracker;
        bit          busy [NUM_SLOTS];
        bit [63:0]   stamp [NUM_SLOTS];
        bit [31:0]   interval [NUM_SLOTS];
        bit [31:0]   hits [NUM_SLOTS];
        bit [31:0]   cap [NUM_SLOTS];
        bit [15:0]   owner [NUM_SLOTS];
        timer_result_t awaited [$];
        int          mismatch_count;

        function new();
            mismatch_count = 0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                busy[i]     = 1'b0;
                stamp[i]    = '0;
                interval[i] = 32'hFFFF_FFFF;
                hits[i]     = '0;
                cap[i]      = '0;
                owner[i]    = '0;
            end
        endfunction

        task flag(string msg);
            $display("%0t ERROR %s", $realtime, msg);
            mismatch_count++;
        endtask

        // Accepted input: update the table and queue what it should produce
        function void take_item(timer_item_t it);
            timer_result_t r;
            bit [64:0]     due;
            bit            found;
            int            i;
            found = 1'b0;
            if (it.op == ptt_pkg::OP_ADD)
            begin
                r = '{ptt_pkg::KIND_ADD, ptt_pkg::ST_FULL, 4'd0, 16'd0, 1'b0, 1'b1};
                for (i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!found && !busy[i])
                    begin
                        found       = 1'b1;
                        busy[i]     = 1'b1;
                        stamp[i]    = '0;
                        interval[i] = it.period;
                        hits[i]     = '0;
                        cap[i]      = it.limit;
                        owner[i]    = it.tag;
                        r.status    = ptt_pkg::ST_OK;
                        r.slot      = 4'(i);
                    end
                end
                awaited.push_back(r);
            end
            else
            begin
                // Scan in slot order; a 65-bit due time past 64 bits never fires
                for (i = 0; i < NUM_SLOTS; i++)
                begin
                    if (busy[i])
                    begin
                        due = {1'b0, stamp[i]} + {33'd0, interval[i]};
                        if (!due[64] && due[63:0] < it.now)
                        begin
                            hits[i]  = hits[i] + 32'd1;
                            stamp[i] = it.now;
                            r = '{ptt_pkg::KIND_FIRE, ptt_pkg::ST_OK, 4'(i), owner[i],
                                  1'b0, 1'b0};
                            // Retired slot goes back to idle, limit stays
                            if (cap[i] != 0 && cap[i] < hits[i])
                            begin
                                r.retired   = 1'b1;
                                busy[i]     = 1'b0;
                                stamp[i]    = '0;
                                interval[i] = 32'hFFFF_FFFF;
                                hits[i]     = '0;
                                owner[i]    = '0;
                            end
                            awaited.push_back(r);
                        end
                    end
                end
                r = '{ptt_pkg::KIND_DONE, ptt_pkg::ST_OK, 4'd0, 16'd0, 1'b0, 1'b1};
                awaited.push_back(r);
            end
        endfunction

        // Accepted output: compare with the oldest expectation
        task match_result(timer_result_t got);
            timer_result_t want;
            if (awaited.size() == 0)
            begin
                flag($sformatf("unexpected result kind %0d slot %0d", got.kind, got.slot));
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind)
                flag($sformatf("kind got %0d exp %0d", got.kind, want.kind));
            if (got.status !== want.status)
                flag($sformatf("status got %0d exp %0d", got.status, want.status));
            if (got.slot !== want.slot)
                flag($sformatf("slot got %0d exp %0d", got.slot, want.slot));
            if (got.tag !== want.tag)
                flag($sformatf("fired_tag got %h exp %h", got.tag, want.tag));
            if (got.retired !== want.retired)
                flag($sformatf("retired got %0d exp %0d", got.retired, want.retired));
            if (got.last !== want.last)
                flag($sformatf("last got %0d exp %0d", got.last, want.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = 1'b0;
    logic [31:0] period = '0;
    logic [31:0] max_fires = '0;
    logic [15:0] task_tag = '0;
    logic [63:0] now = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic        status;
    logic [3:0]  slot;
    logic [15:0] fired_tag;
    logic        retired;
    logic        last;

    task_table_tracker table_sb;
    timer_result_t     seen_res;
    bit                feed_gaps = 1'b1;
    bit                drain_stalls = 1'b1;
    bit                hold_off = 1'b0;
    int                items_sent = 0;

    periodic_timer_task_table_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .period    (period),
        .max_fires (max_fires),
        .task_tag  (task_tag),
        .now       (now),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .status    (status),
        .slot      (slot),
        .fired_tag (fired_tag),
        .retired   (retired),
        .last      (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Offer one item, with random idle cycles first, and hold it until the transfer
    task automatic send_item(timer_item_t it);
        while (feed_gaps && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= it.op;
        period    <= it.period;
        max_fires <= it.limit;
        task_tag  <= it.tag;
        now       <= it.now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        table_sb.take_item(it);
        items_sent++;
    endtask

    // Long receiver hold-off while the sender keeps offering items
    initial
    begin
        wait (items_sent >= 176);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Output side: check each transfer, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_res = '{kind, status, slot, fired_tag, retired, last};
            table_sb.match_result(seen_res);
        end
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= !(drain_stalls && $urandom_range(99) < 23);
    end

    initial
    begin
        timer_item_t it;
        logic [63:0] wall;
        int          pick;
        table_sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty tick, field extremes, retirement, sum overflow
        send_item('{ptt_pkg::OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 64'd0});
        send_item('{ptt_pkg::OP_ADD, 32'd0, 32'd3, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF});
        send_item('{ptt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 64'd0});
        send_item('{ptt_pkg::OP_ADD, 32'd5, 32'd1, 16'h1234, 64'd0});
        send_item('{ptt_pkg::OP_TICK, 32'd0, 32'd0, 16'd0, 64'd0});
        send_item('{ptt_pkg::OP_TICK, 32'd0, 32'd0, 16'd0, 64'd1});
        send_item('{ptt_pkg::OP_TICK, 32'd0, 32'd0, 16'd0, 64'd7});
        send_item('{ptt_pkg::OP_TICK, 32'd0, 32'd0, 16'd0, 64'd13});
        send_item('{ptt_pkg::OP_TICK, 32'd0, 32'd0, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF});
        send_item('{ptt_pkg::OP_TICK, 32'd0, 32'd0, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF});
        // Fill every free slot, then one more add to hit table full
        repeat (16)
        begin
            it = '{ptt_pkg::OP_ADD, 32'($urandom_range(0, 20)), 32'($urandom_range(1, 3)),
                   16'($urandom), {$urandom, $urandom}};
            send_item(it);
        end

        // Random: mostly ticks on a rising clock with small periods and limits
        wall = 64'd0;
        for (int n = 0; n < 444; n++)
        begin
            if (n == 250)
            begin
                feed_gaps    = 1'b0;
                drain_stalls = 1'b0;
            end
            if (n == 350)
            begin
                feed_gaps    = 1'b1;
                drain_stalls = 1'b1;
            end
            pick = $urandom_range(99);
            it = '{ptt_pkg::OP_TICK, $urandom, $urandom, 16'($urandom), {$urandom, $urandom}};
            if (pick < 4)
            begin
                // Odd time stamp; an upward jump becomes the new clock
                if (it.now > wall && it.now < 64'hF000_0000_0000_0000)
                    wall = it.now;
            end
            else if (pick < 6)
            begin
                it.op = ptt_pkg::OP_ADD;
                if ($urandom_range(1) == 0)
                    it.limit = 32'($urandom_range(1, 4));
            end
            else if (pick < 48)
            begin
                it.op     = ptt_pkg::OP_ADD;
                it.period = 32'($urandom_range(0, 30));
                it.limit  = ($urandom_range(99) < 1) ? 32'd0 : 32'($urandom_range(1, 4));
            end
            else
            begin
                wall   = wall + 64'($urandom_range(0, 40));
                it.now = wall;
            end
            send_item(it);
        end
        in_valid <= 1'b0;

        // Drain, then allow a full scan for anything stray
        while (table_sb.awaited.size() != 0)
            @(posedge clk);
        repeat (NUM_SLOTS + 10) @(posedge clk);
        if (table_sb.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hang guard
    initial
    begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== periodic_timer_task_table_core.f =====
rtl/core/ptt_pkg.sv
rtl/core/ptt_mem.sv
rtl/core/ptt_eval.sv
rtl/core/periodic_timer_task_table_core.sv
sim/tb_top.sv
